FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on clocked checker logic.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted (active low).
`define CHK_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CHK_ASSERT_NR(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/clnw_pkg.sv
// ----------------------------------------------------------------------------
// clnw_pkg
// Types and constants for the character display number writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clnw_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam logic [31:0] VALUE_MASK = (VALUE_WIDTH >= 32) ? 32'hFFFF_FFFF :
        32'((64'd1 << VALUE_WIDTH) - 64'd1);

    localparam int DIGIT_SLOTS = 10;
    localparam int CNT_W       = 4;

    // request codes
    localparam logic [2:0] OP_INIT = 3'd0;
    localparam logic [2:0] OP_CMD  = 3'd1;
    localparam logic [2:0] OP_DATA = 3'd2;
    localparam logic [2:0] OP_DEC  = 3'd3;
    localparam logic [2:0] OP_HEX  = 3'd4;

    // x / 10 == (x * DEC_RECIP) >> DEC_SHIFT for every 32-bit x
    localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
    localparam int          DEC_SHIFT = 35;

    localparam logic [7:0] ASCII_DIGIT = 8'h30;
    localparam logic [7:0] ASCII_ALPHA = 8'h37;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_BYTE,
        ST_DIV_MUL,
        ST_DIV_FIX,
        ST_EMIT
    } state_t;

    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h38;  // 8-bit bus, two lines, 5x8 font
            2'd1:    b = 8'h0E;  // display on, cursor on
            2'd2:    b = 8'h01;  // clear
            2'd3:    b = 8'h80;  // home to first line
            default: b = 8'h80;
        endcase
        return b;
    endfunction

endpackage

FILE: sv/character_lcd_number_writer_unit.sv
// ----------------------------------------------------------------------------
// character_lcd_number_writer_unit
// Turns display requests into the byte transfers of a character LCD.
// ----------------------------------------------------------------------------
// Input channel s_*: one request per item, s_tdata = {value, operation}.
//   operation 0 init (four commands), 1 command byte, 2 data byte,
//   3 decimal number, 4 hex number; codes 5..7 are dropped with no output.
// Output channel m_*: one transfer per item, m_tdata = bus byte,
//   m_tuser = register select (1 = character data), m_tlast on the final
//   transfer of a request.
// Timing: a request is taken while idle, then the block is busy.
//   Init gives one transfer per cycle while the output is not stalled,
//   command/data a single transfer. Decimal: one shared multiplier by the
//   reciprocal gives a digit per multiply step and fix step, hex a digit
//   every cycle; then one digit goes out per cycle while not stalled.
// The output register holds a finished transfer; s_tready returns high
//   once the last transfer sits there, even while it is not yet taken.
// A stall on m_tready holds the waiting transfer and pauses the init, byte
//   and digit output steps; digit extraction runs on. Nothing is lost.
// Reset (aresetn low, synchronous) empties the output and returns to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module character_lcd_number_writer_unit
    import clnw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] operation, [34:3] value, [39:35] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] bus_byte
    output logic        m_tuser,   // [0] register_select
    output logic        m_tlast
);

    state_t state_reg, state_next;

    logic [31:0]      rem_reg, rem_next;
    logic [63:0]      prod_reg;
    logic             hex_reg, hex_next;
    logic             rs_reg, rs_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [3:0]       digit_reg [DIGIT_SLOTS];
    logic             digit_we;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [7:0]       m_tdata_reg, m_tdata_next;
    logic             m_tuser_reg, m_tuser_next;
    logic             m_tlast_reg, m_tlast_next;

    logic [2:0]  in_op;
    logic [31:0] in_value;
    logic        accept;
    logic        out_free;
    logic [31:0] quot;
    logic [31:0] quot_dec;
    logic [3:0]  digit;
    logic [3:0]  digit_dec;
    logic [3:0]  emit_digit;
    logic [7:0]  emit_char;

    assign in_op    = s_tdata[2:0];
    assign in_value = s_tdata[34:3];
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // shared divide step: hex is a shift, decimal uses the registered product
    assign quot_dec  = 32'(prod_reg[63:DEC_SHIFT]);
    assign digit_dec = 4'(rem_reg - ((quot_dec << 3) + (quot_dec << 1)));
    assign quot      = hex_reg ? (rem_reg >> 4) : quot_dec;
    assign digit     = hex_reg ? rem_reg[3:0] : digit_dec;

    assign emit_digit = digit_reg[idx_reg];
    assign emit_char  = (emit_digit > 4'd9) ? ASCII_ALPHA + 8'(emit_digit)
                                            : ASCII_DIGIT + 8'(emit_digit);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_op)
                        OP_INIT:         state_next = ST_INIT;
                        OP_CMD, OP_DATA: state_next = ST_BYTE;
                        OP_DEC:          state_next = ST_DIV_MUL;
                        OP_HEX:          state_next = ST_DIV_FIX;
                        default:         state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INIT: begin
                if (out_free && idx_reg == CNT_W'(3)) state_next = ST_IDLE;
            end
            ST_BYTE: begin
                if (out_free) state_next = ST_IDLE;
            end
            ST_DIV_MUL: state_next = ST_DIV_FIX;
            ST_DIV_FIX: begin
                if (quot == '0)   state_next = ST_EMIT;
                else if (!hex_reg) state_next = ST_DIV_MUL;
            end
            ST_EMIT: begin
                if (out_free && idx_reg == '0) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_tready      = (state_reg == ST_IDLE);
        rem_next      = rem_reg;
        hex_next      = hex_reg;
        rs_next       = rs_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        digit_we      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    rem_next   = in_value & VALUE_MASK;
                    hex_next   = (in_op == OP_HEX);
                    rs_next    = (in_op == OP_DATA);
                    idx_next   = '0;
                    count_next = '0;
                end
            end
            ST_INIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = init_byte(idx_reg[1:0]);
                    m_tuser_next  = 1'b0;
                    m_tlast_next  = (idx_reg == CNT_W'(3));
                    idx_next      = idx_reg + CNT_W'(1);
                end
            end
            ST_BYTE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = rem_reg[7:0];
                    m_tuser_next  = rs_reg;
                    m_tlast_next  = 1'b1;
                end
            end
            ST_DIV_MUL: ;
            ST_DIV_FIX: begin
                digit_we   = 1'b1;
                rem_next   = quot;
                count_next = count_reg + CNT_W'(1);
                idx_next   = count_reg;  // most significant digit goes out first
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = emit_char;
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = (idx_reg == '0);
                    idx_next      = idx_reg - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
            count_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        hex_reg     <= hex_next;
        rs_reg      <= rs_next;
        prod_reg    <= 64'(rem_reg) * 64'(DEC_RECIP);
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
        if (digit_we) begin
            digit_reg[count_reg] <= digit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: sv/clnw_checker.sv
// ----------------------------------------------------------------------------
// clnw_checker
// Port-level checks for the character display number writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clnw_checker
    import clnw_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    `CHK_ASSERT_NR(a_reset_empties_output, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

    `CHK_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output item changed")

    `CHK_ASSERT(a_busy_after_byte, aclk, aresetn, s_tvalid && s_tready && (s_tdata[2:0] == OP_CMD || s_tdata[2:0] == OP_DATA) |=> !s_tready, "ready during byte request")

    `CHK_ASSERT(a_init_busy, aclk, aresetn, s_tvalid && s_tready && s_tdata[2:0] == OP_INIT |=> !s_tready ##1 !s_tready, "init sequence accepted new request too early")

endmodule

bind character_lcd_number_writer_unit clnw_checker u_clnw_checker (.*);

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the character LCD number writer. Requests go in
// through a queued stream driver and are predicted as display byte
// transfers; a monitor checks every output item against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import clnw_pkg::*;

    // codes with no behavior, dropped by the block
    localparam logic [2:0] OP_NONE_FIRST = 3'd5;
    localparam logic [2:0] OP_NONE_LAST  = 3'd7;

    // display set-up sequence
    localparam logic [7:0] LCD_FUNC_SET = 8'h38;
    localparam logic [7:0] LCD_DISP_ON  = 8'h0E;
    localparam logic [7:0] LCD_CLEAR    = 8'h01;
    localparam logic [7:0] LCD_HOME     = 8'h80;

    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 64;
    localparam int PHASE_ITEMS  = 60;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] value;
    } lcd_request_t;

    typedef struct packed {
        logic       rs;
        logic [7:0] bus;
        logic       last;
    } lcd_xfer_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    lcd_request_t pending_reqs[$];
    lcd_xfer_t    expected_xfers[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asks      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int errors         = 0;
    int n_requests     = 0;
    int n_dropped      = 0;
    int n_numbers      = 0;
    int n_xfers        = 0;
    logic drv_offering;

    // digit splitter state
    logic [31:0] split_rest;
    logic [3:0]  split_digits[DIGIT_SLOTS];
    int          split_count;

    character_lcd_number_writer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
    end

    task automatic push_xfer(input logic rs, input logic [7:0] bus, input logic last);
        lcd_xfer_t x;
        x.rs   = rs;
        x.bus  = bus;
        x.last = last;
        expected_xfers.push_back(x);
    endtask

    // expected transfers for one accepted request
    task automatic predict_transfers(input lcd_request_t r);
        logic [31:0] base;
        logic [3:0]  d;
        logic [7:0]  ch;
        case (r.op)
            OP_INIT: begin
                push_xfer(1'b0, LCD_FUNC_SET, 1'b0);
                push_xfer(1'b0, LCD_DISP_ON, 1'b0);
                push_xfer(1'b0, LCD_CLEAR, 1'b0);
                push_xfer(1'b0, LCD_HOME, 1'b1);
            end
            OP_CMD:  push_xfer(1'b0, r.value[7:0], 1'b1);
            OP_DATA: push_xfer(1'b1, r.value[7:0], 1'b1);
            OP_DEC, OP_HEX: begin
                base = (r.op == OP_DEC) ? 32'd10 : 32'd16;
                split_rest = r.value & VALUE_MASK;
                split_count = 0;
                do begin
                    split_digits[split_count] = 4'(split_rest % base);
                    split_count++;
                    split_rest = split_rest / base;
                end while (split_rest != 0 && split_count < DIGIT_SLOTS);
                // most significant digit goes out first
                for (int i = split_count - 1; i >= 0; i--) begin
                    d  = split_digits[i];
                    ch = (d > 4'd9) ? {4'h0, d} + ASCII_ALPHA : {4'h0, d} + ASCII_DIGIT;
                    push_xfer(1'b1, ch, i == 0);
                end
            end
            default: ;
        endcase
    endtask

    // driver: offers the head of the pending queue, holds it until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            drv_offering = s_tvalid;
            if (s_tvalid && s_tready) begin
                predict_transfers(pending_reqs[0]);
                if (pending_reqs[0].op > OP_HEX) n_dropped++;
                else n_requests++;
                pending_reqs.pop_front();
                drv_offering = 1'b0;
            end
            if (!drv_offering) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, pending_reqs[0].value, pending_reqs[0].op};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_xfers.size() == 0) begin
                $display("%0t: unexpected transfer rs=%0b byte=%02h last=%0b",
                         $time, m_tuser, m_tdata, m_tlast);
                errors++;
            end else begin
                if (m_tuser !== expected_xfers[0].rs || m_tdata !== expected_xfers[0].bus ||
                    m_tlast !== expected_xfers[0].last) begin
                    $display("%0t: transfer mismatch: expected rs=%0b byte=%02h last=%0b, got rs=%0b byte=%02h last=%0b",
                             $time, expected_xfers[0].rs, expected_xfers[0].bus,
                             expected_xfers[0].last, m_tuser, m_tdata, m_tlast);
                    errors++;
                end
                expected_xfers.pop_front();
                n_xfers++;
            end
        end
    end

    task automatic queue_request(input logic [2:0] op, input logic [31:0] value);
        lcd_request_t r;
        r.op    = op;
        r.value = value;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] p;
        p = 32'd1;
        case ($urandom_range(6))
            0: return 32'($urandom_range(9));
            1: return 32'($urandom_range(255));
            2: return $urandom >> $urandom_range(31);
            3: return 32'hFFFF_FFFF >> $urandom_range(31);
            4: begin
                // around a power of ten
                repeat ($urandom_range(9)) p = p * 32'd10;
                return p - 32'($urandom_range(1));
            end
            default: return $urandom;
        endcase
    endfunction

    // count only requests that do something; dropped codes are extra noise
    task automatic queue_random(input int count);
        int done;
        int pick;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 10)      queue_request(OP_INIT, $urandom);
            else if (pick < 20) queue_request(OP_CMD, $urandom);
            else if (pick < 30) queue_request(OP_DATA, $urandom);
            else if (pick < 62) queue_request(OP_DEC, pick_value());
            else if (pick < 94) queue_request(OP_HEX, pick_value());
            else queue_request(3'($urandom_range(OP_NONE_LAST, OP_NONE_FIRST)), $urandom);
            if (pick < 94) done++;
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        @(negedge aclk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        queue_random(count);
        wait (pending_reqs.size() == 0);
    endtask

    initial begin
        wait (aresetn);
        @(negedge aclk);
        // directed part
        queue_request(OP_INIT, 32'h0000_0000);
        queue_request(OP_CMD, 32'h0000_0000);
        queue_request(OP_CMD, 32'hFFFF_FFFF);
        queue_request(OP_DATA, 32'h0000_0041);
        queue_request(OP_DATA, 32'hA5A5_A5FF);
        queue_request(OP_DEC, 32'd0);
        queue_request(OP_DEC, 32'd9);
        queue_request(OP_DEC, 32'd10);
        queue_request(OP_DEC, 32'd1_000_000_000);
        queue_request(OP_DEC, 32'd999_999_999);
        queue_request(OP_DEC, 32'hFFFF_FFFF);
        queue_request(OP_HEX, 32'h0);
        queue_request(OP_HEX, 32'hA);
        queue_request(OP_HEX, 32'h10);
        queue_request(OP_HEX, 32'hDEAD_BEEF);
        queue_request(OP_HEX, 32'hFFFF_FFFF);
        queue_request(OP_HEX, 32'h8000_0000);
        queue_request(OP_NONE_FIRST, 32'hFFFF_FFFF);
        queue_request(OP_NONE_FIRST + 3'd1, 32'h1234_5678);
        queue_request(OP_NONE_LAST, 32'h0);
        queue_request(OP_INIT, 32'hFFFF_FFFF);
        wait (pending_reqs.size() == 0);

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(76, 0, PHASE_ITEMS);
        run_phase(0, 76, PHASE_ITEMS);
        run_phase(9, 9, PHASE_ITEMS);

        // back-pressure: output held off while the sender keeps offering
        @(negedge aclk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asks++;
        queue_random(PHASE_ITEMS);
        wait (pending_reqs.size() == 0);

        wait (expected_xfers.size() == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d requests (%0d dropped codes), %0d transfers checked",
                 n_requests, n_dropped, n_xfers);
        $display("idle mixes: none, sender 76%%, receiver 76%%, both 9%%, long output hold-off");
        if (errors == 0 && expected_xfers.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout, %0d transfers still expected", $time, expected_xfers.size());
        $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/clnw_pkg.sv
sv/character_lcd_number_writer_unit.sv
sv/clnw_checker.sv
tb/sv/tb.sv
